@@ src/nnir_pkg.sv @@
// ----------------------------------------------------------------------------
// nnir_pkg
// Shared types and constants for the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnir_pkg;

  localparam int PIX_W      = 24;
  localparam int SRC_CFG_W  = 9;
  localparam int DST_CFG_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int DEF_MAX_SRC_DIM = 256;
  localparam int DEF_MAX_DST_DIM = 4096;
  localparam int CFG_DIM_RESET   = 256;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  // transaction opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             frame_end;
  } out_item_t;

endpackage

@@ src/nearest_neighbor_image_resize_top.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_image_resize_top
// Nearest-neighbor image scaler built around a single-port-per-side frame store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries two kinds of
//   transaction. OP_LOAD writes in_data.pixel_in to the frame store at the
//   next raster position; the load pointer wraps after src_width*src_height.
//   OP_FETCH returns the next destination pixel in raster order on the output
//   channel (out_valid / out_stall / out_data), with row_end and frame_end.
//   Config port (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
//   ready; program it only while the block is idle. A write stalls the input
//   while the frame size is recomputed.
// Sequencing (SW = bits needed to hold MAX_SRC_DIM, 9 by default):
//   OP_LOAD produces nothing and leaves the block idle for the next transaction.
//   OP_FETCH steps through multiply, divider load, divide, address, store
//   read and output register stages, with the input stalled until the
//   result is loaded. The divide is a restoring divider that forms the
//   source coordinates one quotient bit per cycle (x and y in parallel).
// Reset: load pointer and output counters go to zero, registers to 256
//   (limited to the parameter maxima). The store is not cleared; no pass.
// Back-pressure: the result sits in an output register while out_stall is
//   high; input is still accepted, a further fetch runs and then waits.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_resize_top #(
  parameter int MAX_SRC_DIM = nnir_pkg::DEF_MAX_SRC_DIM,
  parameter int MAX_DST_DIM = nnir_pkg::DEF_MAX_DST_DIM
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  nnir_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output nnir_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nnir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nnir_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nnir_pkg::*;

  // widths
  localparam int SW          = $clog2(MAX_SRC_DIM + 1);   // effective source dim
  localparam int DW          = $clog2(MAX_DST_DIM + 1);   // effective dest dim
  localparam int CW          = $clog2(MAX_DST_DIM);       // dest row/col counter
  localparam int STORE_DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int SAW         = $clog2(STORE_DEPTH);       // store address
  localparam int PW          = CW + SW;                   // counter * source dim
  localparam int NW          = PW + 2;                    // 2*c*s + d
  localparam int AW          = (NW > DW + SW) ? NW : DW + SW;
  localparam int PSW         = 2 * SW;
  localparam int CNW         = $clog2(SW);

  localparam int RST_SW   = (CFG_DIM_RESET > MAX_SRC_DIM) ? MAX_SRC_DIM : CFG_DIM_RESET;
  localparam int RST_DW   = (CFG_DIM_RESET > MAX_DST_DIM) ? MAX_DST_DIM : CFG_DIM_RESET;
  localparam int RST_SIZE = RST_SW * RST_SW;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_ADDR = 3'd4;
  localparam logic [2:0] ST_READ = 3'd5;
  localparam logic [2:0] ST_DATA = 3'd6;

  // Zero acts as one, oversize acts as the maximum.
  function automatic logic [SW-1:0] eff_src(input logic [SRC_CFG_W-1:0] v);
    if (v == '0) begin
      return SW'(1);
    end else if (32'(v) > 32'(MAX_SRC_DIM)) begin
      return SW'(MAX_SRC_DIM);
    end else begin
      return SW'(v);
    end
  endfunction

  function automatic logic [DW-1:0] eff_dst(input logic [DST_CFG_W-1:0] v);
    if (v == '0) begin
      return DW'(1);
    end else if (32'(v) > 32'(MAX_DST_DIM)) begin
      return DW'(MAX_DST_DIM);
    end else begin
      return DW'(v);
    end
  endfunction

  // control state
  logic [2:0]     state_r, state_nxt;
  logic [SAW-1:0] li_r, li_nxt;
  logic [CW-1:0]  out_col_r, out_col_nxt;
  logic [CW-1:0]  out_row_r, out_row_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           settle_r, settle_nxt;
  logic [SW-1:0]  sw_r, sw_nxt, sh_r, sh_nxt;
  logic [DW-1:0]  dw_r, dw_nxt, dh_r, dh_nxt;
  logic [SAW:0]   size_r, size_nxt;

  // datapath
  logic [CW-1:0]  col_cur_r, col_cur_nxt, row_cur_r, row_cur_nxt;
  logic           re_r, re_nxt, fe_r, fe_nxt;
  logic [PW-1:0]  prod_x_r, prod_x_nxt, prod_y_r, prod_y_nxt;
  logic [AW-1:0]  rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  logic [AW-1:0]  dvs_x_r, dvs_x_nxt, dvs_y_r, dvs_y_nxt;
  logic [SW-1:0]  qx_r, qx_nxt, qy_r, qy_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [SAW-1:0] addr_r, addr_nxt;
  logic [PIX_W-1:0] rd_data_r;
  out_item_t      out_data_r;

  logic [PIX_W-1:0] store_mem [STORE_DEPTH];

  logic           in_fire, out_fire, cfg_fire;
  logic           wr_en, rd_en, out_load;
  logic [SAW-1:0] wa;
  logic [SAW:0]   wa_inc;
  logic [CW-1:0]  col_fix, row_fix;
  logic           re_now, fe_now;
  logic [SW-1:0]  sx, sy;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != ST_IDLE) || settle_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // load pointer: re-base if a resize left it past the frame
  assign wa     = ({1'b0, li_r} >= size_r) ? '0 : li_r;
  assign wa_inc = {1'b0, wa} + (SAW+1)'(1);
  assign wr_en  = in_fire && (in_data.op == OP_LOAD);

  // output counters: re-base if a resize left them past the frame
  assign col_fix = (DW'(out_col_r) >= dw_r) ? '0 : out_col_r;
  assign row_fix = (DW'(out_row_r) >= dh_r) ? '0 : out_row_r;
  assign re_now  = (DW'(col_fix) == dw_r - DW'(1));
  assign fe_now  = re_now && (DW'(row_fix) == dh_r - DW'(1));

  // clamp quotients to the source maximum
  assign sx = (qx_r > sw_r - SW'(1)) ? sw_r - SW'(1) : qx_r;
  assign sy = (qy_r > sh_r - SW'(1)) ? sh_r - SW'(1) : qy_r;

  assign rd_en    = (state_r == ST_READ);
  assign out_load = (state_r == ST_DATA) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt   = state_r;
    li_nxt      = li_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    col_cur_nxt = col_cur_r;
    row_cur_nxt = row_cur_r;
    re_nxt      = re_r;
    fe_nxt      = fe_r;
    prod_x_nxt  = prod_x_r;
    prod_y_nxt  = prod_y_r;
    rem_x_nxt   = rem_x_r;
    rem_y_nxt   = rem_y_r;
    dvs_x_nxt   = dvs_x_r;
    dvs_y_nxt   = dvs_y_r;
    qx_nxt      = qx_r;
    qy_nxt      = qy_r;
    cnt_nxt     = cnt_r;
    addr_nxt    = addr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.op == OP_LOAD) begin
            li_nxt = (wa_inc >= size_r) ? '0 : wa_inc[SAW-1:0];
          end else begin
            col_cur_nxt = col_fix;
            row_cur_nxt = row_fix;
            re_nxt      = re_now;
            fe_nxt      = fe_now;
            if (re_now) begin
              out_col_nxt = '0;
              out_row_nxt = fe_now ? '0 : row_fix + CW'(1);
            end else begin
              out_col_nxt = col_fix + CW'(1);
              out_row_nxt = row_fix;
            end
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_x_nxt = PW'(col_cur_r) * PW'(sw_r);
        prod_y_nxt = PW'(row_cur_r) * PW'(sh_r);
        state_nxt  = ST_LOAD;
      end
      ST_LOAD: begin
        // numerator 2*c*s + d, divisor 2*d aligned to the top quotient bit
        rem_x_nxt = AW'({prod_x_r, 1'b0}) + AW'(dw_r);
        rem_y_nxt = AW'({prod_y_r, 1'b0}) + AW'(dh_r);
        dvs_x_nxt = AW'({dw_r, 1'b0}) << (SW - 1);
        dvs_y_nxt = AW'({dh_r, 1'b0}) << (SW - 1);
        cnt_nxt   = CNW'(SW - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (rem_x_r >= dvs_x_r) begin
          rem_x_nxt = rem_x_r - dvs_x_r;
          qx_nxt    = {qx_r[SW-2:0], 1'b1};
        end else begin
          qx_nxt    = {qx_r[SW-2:0], 1'b0};
        end
        if (rem_y_r >= dvs_y_r) begin
          rem_y_nxt = rem_y_r - dvs_y_r;
          qy_nxt    = {qy_r[SW-2:0], 1'b1};
        end else begin
          qy_nxt    = {qy_r[SW-2:0], 1'b0};
        end
        dvs_x_nxt = dvs_x_r >> 1;
        dvs_y_nxt = dvs_y_r >> 1;
        cnt_nxt   = cnt_r - CNW'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        addr_nxt  = SAW'(PSW'(sy) * PSW'(sw_r) + PSW'(sx));
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_DATA;
      end
      ST_DATA: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  // config registers hold effective sizes
  always_comb begin
    sw_nxt     = sw_r;
    sh_nxt     = sh_r;
    dw_nxt     = dw_r;
    dh_nxt     = dh_r;
    settle_nxt = cfg_fire;
    size_nxt   = (SAW+1)'(PSW'(sw_r) * PSW'(sh_r));
    if (cfg_fire) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  sw_nxt = eff_src(cfg_data[SRC_CFG_W-1:0]);
        REG_SRC_HEIGHT: sh_nxt = eff_src(cfg_data[SRC_CFG_W-1:0]);
        REG_DST_WIDTH:  dw_nxt = eff_dst(cfg_data[DST_CFG_W-1:0]);
        REG_DST_HEIGHT: dh_nxt = eff_dst(cfg_data[DST_CFG_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      li_r        <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_valid_r <= 1'b0;
      settle_r    <= 1'b0;
      sw_r        <= SW'(RST_SW);
      sh_r        <= SW'(RST_SW);
      dw_r        <= DW'(RST_DW);
      dh_r        <= DW'(RST_DW);
      size_r      <= (SAW+1)'(RST_SIZE);
    end else begin
      state_r     <= state_nxt;
      li_r        <= li_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      out_valid_r <= out_valid_nxt;
      settle_r    <= settle_nxt;
      sw_r        <= sw_nxt;
      sh_r        <= sh_nxt;
      dw_r        <= dw_nxt;
      dh_r        <= dh_nxt;
      size_r      <= size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_cur_r <= col_cur_nxt;
    row_cur_r <= row_cur_nxt;
    re_r      <= re_nxt;
    fe_r      <= fe_nxt;
    prod_x_r  <= prod_x_nxt;
    prod_y_r  <= prod_y_nxt;
    rem_x_r   <= rem_x_nxt;
    rem_y_r   <= rem_y_nxt;
    dvs_x_r   <= dvs_x_nxt;
    dvs_y_r   <= dvs_y_nxt;
    qx_r      <= qx_nxt;
    qy_r      <= qy_nxt;
    cnt_r     <= cnt_nxt;
    addr_r    <= addr_nxt;
    if (out_load) begin
      out_data_r.pixel_out <= rd_data_r;
      out_data_r.row_end   <= re_r;
      out_data_r.frame_end <= fe_r;
    end
  end

  // frame store: one write port (loads), one registered read port (fetches)
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wa] <= in_data.pixel_in;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[addr_r];
    end
  end

endmodule

@@ src/nnir_checker.sv @@
// ----------------------------------------------------------------------------
// nnir_checker
// Port-level checks for the nearest-neighbor image scaler, bound to the top.
// ----------------------------------------------------------------------------
module nnir_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input nnir_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input nnir_pkg::out_item_t             out_data
);
  import nnir_pkg::*;

  // held result must not change under back-pressure
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // no result pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // frame end is always also a row end
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.frame_end || out_data.row_end))
    else $error("frame_end without row_end");

  // a fetch occupies the block: input stalls in the next cycle
  a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.op == OP_FETCH) |=> in_stall)
    else $error("input taken while a fetch is in flight");

  // no transaction produces a result in the following cycle
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared one cycle after acceptance");

endmodule

bind nearest_neighbor_image_resize_top nnir_checker u_nnir_checker (.*);
